[rtl/kmst_pkg.sv]
// Package for the keyed metric statistics table.
// Holds request and result beat types, request and status codes; no dependencies.
package kmst_pkg;

    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_INCR  = 2'd1;
    localparam logic [1:0] REQ_GET   = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] KIND_COUNTER = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        key_hash;
        logic signed [31:0] data_value;
        logic [1:0]         value_kind;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         kind_out;
        logic signed [31:0] current_value;
        logic signed [31:0] previous_value;
        logic signed [31:0] minimum_value;
        logic signed [31:0] maximum_value;
        logic signed [63:0] total_sum;
        logic [31:0]        sample_count;
        logic signed [31:0] window_average;
    } rsp_t;

endpackage

[rtl/kmst_front.sv]
// Front end of the keyed metric statistics table: a two-entry request queue.
// Depends on kmst_pkg for the request beat type.
module kmst_front import kmst_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic q_valid,
    input  logic q_ready,
    output req_t q_data
);
    req_t       slot_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            slot_reg[wr_ptr_reg] <= s_data;
        end
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (s_valid && s_ready) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_valid && q_ready) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, s_valid && s_ready} - {1'b0, q_valid && q_ready};
        end
    end
endmodule

[rtl/kmst_divider.sv]
// Restoring divider for the window average: signed dividend by small unsigned divisor.
// One quotient bit per cycle; depends on nothing outside this file.
module kmst_divider #(
    parameter int DW = 35,
    parameter int VW = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic [VW-1:0]        divisor,
    output logic                 done,
    output logic signed [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW:0]   rem_reg;
    logic [VW-1:0] dvs_reg;
    logic          neg_reg, busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;

    assign shifted = {rem_reg[VW-1:0], quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign done    = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                neg_reg  <= dividend[DW-1];
                quo_reg  <= dividend[DW-1] ? -dividend : dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                if (!diff[VW]) begin
                    rem_reg <= diff;
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

[rtl/kmst_back.sv]
// Back end of the keyed metric statistics table: sequencer that searches keys,
// updates the record stores and window, and builds results. Uses kmst_pkg and kmst_divider.
module kmst_back import kmst_pkg::*; #(
    parameter int TABLE_ENTRIES = 16,
    parameter int WINDOW_LENGTH = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_ready,
    input  req_t q_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);
    localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int PW  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int FW  = $clog2(WINDOW_LENGTH + 1);
    localparam int SW  = 32 + FW + 1;
    localparam int WD  = TABLE_ENTRIES * WINDOW_LENGTH;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // Record stores, one row per entry.
    logic [31:0] key_mem  [TABLE_ENTRIES];
    logic [31:0] cur_mem  [TABLE_ENTRIES];
    logic [31:0] prev_mem [TABLE_ENTRIES];
    logic [31:0] min_mem  [TABLE_ENTRIES];
    logic [31:0] max_mem  [TABLE_ENTRIES];
    logic [63:0] sum_mem  [TABLE_ENTRIES];
    logic [31:0] cnt_mem  [TABLE_ENTRIES];
    logic [1:0]  kind_mem [TABLE_ENTRIES];
    logic [PW-1:0] pos_mem  [TABLE_ENTRIES];
    logic [FW-1:0] fill_mem [TABLE_ENTRIES];
    logic [31:0] win_mem  [WD];

    logic [2:0]    state_reg;
    req_t          req_reg;
    logic [CW-1:0] entries_reg;
    logic [CW-1:0] idx_reg;
    logic          found_reg, fresh_reg;
    logic [31:0]   key_rd_reg;
    logic [31:0]   cur_r, prev_r, min_r, max_r, cnt_r;
    logic [63:0]   sum_r;
    logic [1:0]    kind_r;
    logic [PW-1:0] pos_r;
    logic [FW-1:0] fill_r;
    logic [FW-1:0] k_reg;
    logic          sum_pend_reg;
    logic [31:0]   win_rd_reg;
    logic signed [SW-1:0] wsum_reg;
    rsp_t          res_reg;
    rsp_t          out_reg;
    logic          out_valid_reg;
    logic          div_start_reg;
    logic          div_done;
    logic signed [SW-1:0] div_q;

    logic [EW-1:0]  eidx;
    logic [31:0]    newval;
    logic [31:0]    upd_min, upd_max;
    logic [WAW-1:0] win_wa, win_ra;
    logic [PW-1:0]  pos_base;
    logic [PW-1:0]  pos_nx;

    assign eidx    = idx_reg[EW-1:0];
    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Fresh entries start from zero current; increment adds to the old current.
    always_comb begin
        if (req_reg.req_type == REQ_INCR) begin
            newval = (fresh_reg ? 32'd0 : cur_r) + req_reg.data_value;
        end else begin
            newval = req_reg.data_value;
        end
        upd_min = (fresh_reg || cnt_r == 32'd0 || $signed(newval) < $signed(min_r))
                  ? newval : min_r;
        upd_max = (fresh_reg || cnt_r == 32'd0 || $signed(newval) > $signed(max_r))
                  ? newval : max_r;
        pos_base = fresh_reg ? '0 : pos_r;
        pos_nx  = (pos_base == PW'(WINDOW_LENGTH - 1)) ? '0 : pos_base + 1'b1;
        win_wa  = WAW'(eidx * WINDOW_LENGTH) + WAW'(pos_base);
        win_ra  = WAW'(eidx * WINDOW_LENGTH) + WAW'(k_reg);
    end

    kmst_divider #(.DW(SW), .VW(FW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (wsum_reg),
        .divisor  (fill_r),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        key_rd_reg <= key_mem[eidx];
        win_rd_reg <= win_mem[win_ra];
        if (state_reg == S_UPDATE) begin
            key_mem[eidx]  <= req_reg.key_hash;
            cur_mem[eidx]  <= newval;
            prev_mem[eidx] <= fresh_reg ? 32'd0 : cur_r;
            min_mem[eidx]  <= upd_min;
            max_mem[eidx]  <= upd_max;
            sum_mem[eidx]  <= (fresh_reg ? 64'd0 : sum_r) + {{32{newval[31]}}, newval};
            cnt_mem[eidx]  <= (fresh_reg ? 32'd0 : cnt_r) + 32'd1;
            kind_mem[eidx] <= (req_reg.req_type == REQ_INCR) ? KIND_COUNTER
                                                             : req_reg.value_kind;
            pos_mem[eidx]  <= pos_nx;
            fill_mem[eidx] <= fresh_reg ? FW'(1)
                            : (fill_r == FW'(WINDOW_LENGTH)) ? fill_r : fill_r + 1'b1;
            win_mem[win_wa] <= newval;
        end
        if (state_reg == S_READ && req_reg.req_type == REQ_CLEAR && found_reg) begin
            pos_mem[eidx]  <= '0;
            fill_mem[eidx] <= '0;
        end
        if (state_reg == S_READ) begin
            cur_r  <= cur_mem[eidx];
            prev_r <= prev_mem[eidx];
            min_r  <= min_mem[eidx];
            max_r  <= max_mem[eidx];
            sum_r  <= sum_mem[eidx];
            cnt_r  <= cnt_mem[eidx];
            kind_r <= kind_mem[eidx];
            pos_r  <= pos_mem[eidx];
            fill_r <= fill_mem[eidx];
        end

        if (!aresetn) begin
            state_reg     <= S_IDLE;
            entries_reg   <= '0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        req_reg      <= q_data;
                        idx_reg      <= '0;
                        found_reg    <= 1'b0;
                        sum_pend_reg <= 1'b0;
                        state_reg    <= S_SEARCH;
                    end
                end
                // One key compare per cycle; the key read is registered, so it lags the index.
                S_SEARCH: begin
                    if (sum_pend_reg && key_rd_reg == req_reg.key_hash) begin
                        idx_reg   <= idx_reg - 1'b1;
                        found_reg <= 1'b1;
                        state_reg <= S_READ;
                    end else if (idx_reg >= entries_reg) begin
                        found_reg <= 1'b0;
                        state_reg <= S_READ;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    sum_pend_reg <= (idx_reg < entries_reg);
                end
                S_READ: begin
                    fresh_reg <= !found_reg;
                    res_reg   <= '0;
                    if (req_reg.req_type == REQ_SET || req_reg.req_type == REQ_INCR) begin
                        if (found_reg) begin
                            state_reg <= S_UPDATE;
                        end else if (entries_reg == CW'(TABLE_ENTRIES)) begin
                            res_reg.status <= ST_FULL;
                            state_reg      <= S_OUT;
                        end else begin
                            idx_reg     <= entries_reg;
                            entries_reg <= entries_reg + 1'b1;
                            state_reg   <= S_UPDATE;
                        end
                    end else if (!found_reg) begin
                        res_reg.status <= ST_NOTFOUND;
                        state_reg      <= S_OUT;
                    end else if (req_reg.req_type == REQ_GET) begin
                        k_reg        <= '0;
                        wsum_reg     <= '0;
                        sum_pend_reg <= 1'b0;
                        state_reg    <= S_SUM;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_UPDATE: begin
                    state_reg <= S_OUT;
                end
                // Window samples stream out of the memory one per cycle.
                S_SUM: begin
                    if (sum_pend_reg) begin
                        wsum_reg <= wsum_reg + SW'($signed(win_rd_reg));
                    end
                    if (k_reg < fill_r) begin
                        k_reg        <= k_reg + 1'b1;
                        sum_pend_reg <= 1'b1;
                    end else begin
                        sum_pend_reg <= 1'b0;
                        if (!sum_pend_reg || k_reg == fill_r) begin
                            if (sum_pend_reg || fill_r == '0) begin
                                state_reg     <= S_DIV;
                                div_start_reg <= (fill_r != '0);
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (fill_r == '0 || div_done) begin
                        res_reg.kind_out       <= kind_r;
                        res_reg.current_value  <= cur_r;
                        res_reg.previous_value <= prev_r;
                        res_reg.minimum_value  <= min_r;
                        res_reg.maximum_value  <= max_r;
                        res_reg.total_sum      <= sum_r;
                        res_reg.sample_count   <= cnt_r;
                        res_reg.window_average <= (fill_r == '0) ? 32'sd0 : div_q[31:0];
                        state_reg <= S_OUT;
                    end
                end
                // The result moves to the output register once the previous beat has left.
                S_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/keyed_metric_statistics_table.sv]
// Top level of the keyed metric statistics table.
// Depends on kmst_pkg, kmst_front, kmst_back and kmst_divider.

// A request is taken from the queue in the idle state, then searched for by key (one
// compare per entry in use) and read. A set or increment then passes through an update
// state unless the table is full, a get of a known key sums its window samples and runs
// the divider unless the window is empty, and every request ends in a state that loads
// the result register. A result waiting on the output stalls only that last state, and
// a two-beat queue in front lets requests arrive while one is in progress.
module keyed_metric_statistics_table import kmst_pkg::*; #(
    parameter int TABLE_ENTRIES = 16,
    parameter int WINDOW_LENGTH = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);
    logic q_valid, q_ready;
    req_t q_data;

    kmst_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    kmst_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .WINDOW_LENGTH(WINDOW_LENGTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK || m_data.status == ST_NOTFOUND
                     || m_data.status == ST_FULL))
        else $error("illegal status");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_OK) |-> (m_data.sample_count == 32'd0))
        else $error("failed request carries data");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");
endmodule

[dv/keyed_metric_statistics_table_tb.sv]
// Testbench for the keyed metric statistics table: directed and random requests
// checked against a behavioral table model. Depends on kmst_pkg and the top level.
module keyed_metric_statistics_table_tb;
    import kmst_pkg::*;

    localparam int ENTRIES = 16;
    localparam int WIN = 8;
    localparam int STALL_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    keyed_metric_statistics_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // Shadow copy of the metric table.
    int unsigned      used_entries;
    logic [31:0]      tbl_key [ENTRIES];
    logic [31:0]      tbl_cur [ENTRIES];
    logic [31:0]      tbl_prev [ENTRIES];
    logic [31:0]      tbl_min [ENTRIES];
    logic [31:0]      tbl_max [ENTRIES];
    logic [63:0]      tbl_sum [ENTRIES];
    logic [31:0]      tbl_cnt [ENTRIES];
    logic [1:0]       tbl_kind [ENTRIES];
    logic [31:0]      tbl_win [ENTRIES][WIN];
    int unsigned      tbl_pos [ENTRIES];
    int unsigned      tbl_fill [ENTRIES];

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    logic [31:0] key_pool[$];
    bit failed = 0;
    bit calm;
    int unsigned sent_count = 0;
    int unsigned idle_cycles = 0;

    // Both sides run without idling for a stretch in the middle of the random traffic.
    always_comb calm = (sent_count >= 700 && sent_count < 1000);

    function automatic int find_entry(logic [31:0] key);
        for (int i = 0; i < used_entries; i++)
            if (tbl_key[i] == key) return i;
        return -1;
    endfunction

    function automatic logic [1:0] record_value(logic [31:0] key, logic [31:0] val,
                                                logic [1:0] kind);
        int e;
        int p;
        e = find_entry(key);
        if (e < 0) begin
            if (used_entries >= ENTRIES) return ST_FULL;
            e = used_entries++;
            tbl_key[e] = key;
            tbl_cur[e] = '0;
            tbl_sum[e] = '0;
            tbl_cnt[e] = '0;
            tbl_pos[e] = 0;
            tbl_fill[e] = 0;
            tbl_min[e] = val;
            tbl_max[e] = val;
        end
        tbl_prev[e] = tbl_cur[e];
        tbl_cur[e] = val;
        tbl_kind[e] = kind;
        if (tbl_cnt[e] == 0 || $signed(val) < $signed(tbl_min[e])) tbl_min[e] = val;
        if (tbl_cnt[e] == 0 || $signed(val) > $signed(tbl_max[e])) tbl_max[e] = val;
        tbl_sum[e] = tbl_sum[e] + {{32{val[31]}}, val};
        tbl_cnt[e] = tbl_cnt[e] + 1;
        p = tbl_pos[e];
        tbl_win[e][p] = val;
        tbl_pos[e] = (p + 1) % WIN;
        if (tbl_fill[e] < WIN) tbl_fill[e]++;
        return ST_OK;
    endfunction

    function automatic rsp_t predict_response(req_t r);
        rsp_t o;
        int e;
        longint acc;
        o = '0;
        e = find_entry(r.key_hash);
        case (r.req_type)
            REQ_SET: o.status = record_value(r.key_hash, r.data_value, r.value_kind);
            REQ_INCR: o.status = record_value(r.key_hash,
                (e >= 0 ? tbl_cur[e] : 32'd0) + r.data_value, KIND_COUNTER);
            REQ_GET: begin
                if (e < 0) begin
                    o.status = ST_NOTFOUND;
                end else begin
                    acc = 0;
                    for (int k = 0; k < tbl_fill[e]; k++) acc += $signed(tbl_win[e][k]);
                    o.kind_out = tbl_kind[e];
                    o.current_value = tbl_cur[e];
                    o.previous_value = tbl_prev[e];
                    o.minimum_value = tbl_min[e];
                    o.maximum_value = tbl_max[e];
                    o.total_sum = tbl_sum[e];
                    o.sample_count = tbl_cnt[e];
                    o.window_average = (tbl_fill[e] != 0)
                                       ? 32'(acc / longint'(tbl_fill[e])) : 32'd0;
                end
            end
            default: begin
                if (e < 0) begin
                    o.status = ST_NOTFOUND;
                end else begin
                    tbl_fill[e] = 0;
                    tbl_pos[e] = 0;
                end
            end
        endcase
        return o;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_req(logic [1:0] op, logic [31:0] key, logic [31:0] val,
                             logic [1:0] kind);
        req_t r;
        r.req_type = op;
        r.key_hash = key;
        r.data_value = val;
        r.value_kind = kind;
        pending_reqs.push_back(r);
    endtask

    // Driver: keeps valid up until the beat is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 11)) begin
                    s_data <= pending_reqs[0];
                    expected_rsps.push_back(predict_response(pending_reqs.pop_front()));
                    s_valid <= 1'b1;
                    sent_count <= sent_count + 1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and sink stalls.
    always @(posedge aclk) begin
        rsp_t exp_rsp;
        if (aresetn) begin
            m_ready <= calm || ($urandom_range(0, 99) >= 11);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, m_data);
                    failed = 1;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (exp_rsp !== m_data) begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_rsp, m_data);
                        failed = 1;
                    end
                end
            end
        end
    end

    initial begin
        logic [31:0] k;
        int unsigned op;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: unknown keys, extremes, wrap of increment, window clear.
        queue_req(REQ_GET, 32'hffffffff, 32'd0, 2'd0);
        queue_req(REQ_CLEAR, 32'h0, 32'd0, 2'd0);
        queue_req(REQ_SET, 32'h0, 32'h7fffffff, 2'd0);
        queue_req(REQ_SET, 32'h0, 32'h80000000, 2'd1);
        queue_req(REQ_GET, 32'h0, 32'hffffffff, 2'd3);
        queue_req(REQ_INCR, 32'h0, 32'hffffffff, 2'd2);
        queue_req(REQ_INCR, 32'hffffffff, 32'h7fffffff, 2'd0);
        queue_req(REQ_INCR, 32'hffffffff, 32'h00000001, 2'd0);
        queue_req(REQ_GET, 32'hffffffff, 32'd0, 2'd0);
        queue_req(REQ_CLEAR, 32'hffffffff, 32'd0, 2'd0);
        queue_req(REQ_GET, 32'hffffffff, 32'd0, 2'd0);
        for (int i = 0; i < 9; i++) queue_req(REQ_SET, 32'h0, -32'sd7 - i, 2'd2);
        queue_req(REQ_GET, 32'h0, 32'd0, 2'd0);
        key_pool.push_back(32'h0);
        key_pool.push_back(32'hffffffff);

        // Random: a pool of keys mostly reused; the table fills, then FULL is seen.
        for (int i = 0; i < 1400; i++) begin
            if (key_pool.size() < 20 && $urandom_range(0, 9) == 0) begin
                k = $urandom;
                key_pool.push_back(k);
            end else if ($urandom_range(0, 19) == 0) begin
                k = $urandom;
            end else begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end
            op = $urandom_range(0, 9);
            queue_req(op < 4 ? REQ_SET : op < 6 ? REQ_INCR : op < 9 ? REQ_GET : REQ_CLEAR,
                      k, pick_value(), 2'($urandom_range(0, 3)));
        end
    end

    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
            if (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !s_valid) begin
                repeat (200) @(posedge aclk);
                if (!failed && expected_rsps.size() == 0) begin
                    $display("SUCCESS");
                end else begin
                    $display("FAILURE");
                end
                $finish;
            end
        end
    end
endmodule
